// File: hw/rtl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg: shared types and constants of the gait sequenced servo PWM
// Register indexes, reset values, stream payload layout and the gait pattern
// table that holds the pulse widths of the four base channels.
// ----------------------------------------------------------------------------
package gsp_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_PERIOD_TOP      = 2'd0,
		REG_FRAMES_PER_STEP = 2'd1,
		REG_PAUSE_TICKS     = 2'd2
	} reg_index_t;

	localparam int unsigned CFG_DATA_W = 16;

	// Reset values of the configuration registers
	localparam logic [11:0] PERIOD_TOP_RST      = 12'd1001;
	localparam logic [7:0]  FRAMES_PER_STEP_RST = 8'd10;
	localparam logic [15:0] PAUSE_TICKS_RST     = 16'd25000;

	// Stream payload widths (whole bytes)
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 16;

	// Pattern table: sixteen slots, slots past the gait repeat the neutral stance
	localparam int unsigned TABLE_SLOTS = 16;
	typedef logic [15:0] pat_row_t [TABLE_SLOTS];

	localparam pat_row_t PAT_A = '{16'd80, 16'd80, 16'd103, 16'd103, 16'd80, 16'd80,
		16'd80, 16'd80, 16'd80, 16'd80, 16'd80, 16'd80, 16'd80, 16'd80, 16'd80, 16'd80};
	localparam pat_row_t PAT_B = '{16'd40, 16'd30, 16'd30, 16'd50, 16'd50, 16'd40,
		16'd40, 16'd40, 16'd40, 16'd40, 16'd40, 16'd40, 16'd40, 16'd40, 16'd40, 16'd40};
	localparam pat_row_t PAT_C = '{16'd80, 16'd80, 16'd57, 16'd57, 16'd80, 16'd80,
		16'd80, 16'd80, 16'd80, 16'd80, 16'd80, 16'd80, 16'd80, 16'd80, 16'd80, 16'd80};
	localparam pat_row_t PAT_D = '{16'd40, 16'd50, 16'd50, 16'd30, 16'd30, 16'd40,
		16'd40, 16'd40, 16'd40, 16'd40, 16'd40, 16'd40, 16'd40, 16'd40, 16'd40, 16'd40};

	// Pulse width of one base channel for one table slot
	function automatic logic [15:0] pat_width(input logic [1:0] lane, input logic [3:0] slot);
		logic [15:0] w;
		case (lane)
			2'd0: w = PAT_A[slot];
			2'd1: w = PAT_B[slot];
			2'd2: w = PAT_C[slot];
			2'd3: w = PAT_D[slot];
			default: w = PAT_A[slot];
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/gait_sequenced_servo_pwm.sv
// Timing: a result is registered and valid in the cycle after its item is transferred.
// Throughput: one item per cycle while the receiver takes results; the output
// register lets the next item enter while the previous result is being taken.
// Reset: arst_n clears all counters to step 0 in the pulse phase, loads the
// register defaults and empties the output register.
// ----------------------------------------------------------------------------
// gait_sequenced_servo_pwm: eight-channel servo pulse generator
// Each transferred item with its tick flag set is one timebase tick; each result reports the pin
// levels, gait step and pause flag before the tick, and the frame wrap.
// ----------------------------------------------------------------------------
module gait_sequenced_servo_pwm #(
	parameter int STEP_COUNT = 6,
	parameter int WIDTH_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [gsp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: [0] tick_valid, [7:1] zero
	input  logic [gsp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: [7:0] pin_bits, [10:8] step_index, [11] in_pause, [12] frame_end,
	// [15:13] zero
	output logic [gsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic                            accept;
	logic [11:0]                     tick_count;
	logic [3:0]                      slot;
	logic                            pausing;
	logic                            frame_end;
	logic [7:0]                      pin_bits;
	logic                            out_valid_q;
	logic [gsp_pkg::OUT_TDATA_W-1:0] out_data_q;

	// Input is taken whenever the output register is free or being drained
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	gsp_seq #(
		.STEP_COUNT(STEP_COUNT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept && s_axis_tdata[0]),
		.tick_count(tick_count),
		.slot      (slot),
		.pausing   (pausing),
		.frame_end (frame_end)
	);

	gsp_pins #(
		.WIDTH_BITS(WIDTH_BITS)
	) u_pins (
		.tick_count(tick_count),
		.slot      (slot),
		.pausing   (pausing),
		.pin_bits  (pin_bits)
	);

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {3'd0, frame_end, pausing, slot[2:0], pin_bits};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// File: hw/rtl/gsp_pins.sv
// ----------------------------------------------------------------------------
// gsp_pins: servo pin level decode
// Looks up the four pulse widths of the current gait step and compares each
// against the tick count. Channels 5 to 8 mirror channels 1 to 4.
// ----------------------------------------------------------------------------
module gsp_pins #(
	parameter int WIDTH_BITS = 12
) (
	input  logic [11:0] tick_count,
	input  logic [3:0]  slot,
	input  logic        pausing,
	output logic [7:0]  pin_bits
);

	localparam logic [15:0] WIDTH_MASK = 16'((32'd1 << WIDTH_BITS) - 32'd1);

	logic [3:0] base_hi;

	// One comparator per base channel
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			base_hi[c] = ({4'd0, tick_count} <
				(gsp_pkg::pat_width(2'(c), slot) & WIDTH_MASK));
		end
	end

	// All pins are held low during the pause between steps
	assign pin_bits = pausing ? 8'd0 : {base_hi, base_hi};

endmodule

// File: hw/rtl/gsp_seq.sv
// ----------------------------------------------------------------------------
// gsp_seq: tick, frame, pause and gait step counters
// Holds the configuration registers and the sequencer state, and advances
// the state by one tick on each accepted item whose tick flag is set.
// ----------------------------------------------------------------------------
module gsp_seq #(
	parameter int STEP_COUNT = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [gsp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          advance,
	output logic [11:0]                   tick_count,
	output logic [3:0]                    slot,
	output logic                          pausing,
	output logic                          frame_end
);

	localparam int STEP_W = $clog2(STEP_COUNT);

	logic [11:0]       period_top_q;
	logic [7:0]        frames_per_step_q;
	logic [15:0]       pause_ticks_q;
	logic [11:0]       tick_q;
	logic [7:0]        frame_q;
	logic [STEP_W-1:0] step_q;
	logic [15:0]       pause_q;
	logic              pausing_q;

	logic [STEP_W-1:0] step_next;
	logic [15:0]       pause_inc;
	logic [8:0]        frame_inc;
	logic              wrap;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_top_q      <= gsp_pkg::PERIOD_TOP_RST;
			frames_per_step_q <= gsp_pkg::FRAMES_PER_STEP_RST;
			pause_ticks_q     <= gsp_pkg::PAUSE_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gsp_pkg::REG_PERIOD_TOP:      period_top_q      <= cfg_data[11:0];
				gsp_pkg::REG_FRAMES_PER_STEP: frames_per_step_q <= cfg_data[7:0];
				gsp_pkg::REG_PAUSE_TICKS:     pause_ticks_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Next gait step, wrapping after the last one
	always_comb begin
		if (({1'b0, step_q} + 1'b1) >= (STEP_W + 1)'(STEP_COUNT)) begin
			step_next = '0;
		end else begin
			step_next = step_q + 1'b1;
		end
	end

	assign pause_inc = pause_q + 16'd1;
	assign frame_inc = {1'b0, frame_q} + 9'd1;
	assign wrap      = (tick_q >= period_top_q);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			frame_q   <= '0;
			step_q    <= '0;
			pause_q   <= '0;
			pausing_q <= 1'b0;
		end else if (advance) begin
			if (pausing_q) begin
				// A wrapped pause count also ends the pause
				if (pause_inc >= pause_ticks_q || pause_inc == 16'd0) begin
					pausing_q <= 1'b0;
					pause_q   <= '0;
					step_q    <= step_next;
				end else begin
					pause_q <= pause_inc;
				end
			end else if (!wrap) begin
				tick_q <= tick_q + 12'd1;
			end else begin
				tick_q <= '0;
				if (frame_inc >= {1'b0, frames_per_step_q}) begin
					frame_q <= '0;
					pause_q <= '0;
					if (pause_ticks_q == 16'd0) begin
						step_q <= step_next;
					end else begin
						pausing_q <= 1'b1;
					end
				end else begin
					frame_q <= frame_inc[7:0];
				end
			end
		end
	end

	assign tick_count = tick_q;
	assign slot       = 4'(step_q);
	assign pausing    = pausing_q;
	assign frame_end  = advance && !pausing_q && wrap;

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream-level testbench of the gait sequenced servo PWM
// A directed plan covers reset, the register maxima, zero frame count, zero
// pause, a pause cut short and a tick count above a lowered top. Random phases
// follow, each starting with register writes while the block is idle. Every
// tick transfer is predicted by a local model of the counters, and each result
// transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_TICKS = 1200;
	localparam int SETTLE       = 4;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int LONG_HOLD    = 90;
	localparam int GAIT_STEPS   = 6;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [1:0]                      cfg_index;
	logic [gsp_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	// tdata: [0] tick_valid, [7:1] zero
	logic [gsp_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	// tdata: [7:0] pin_bits, [10:8] step_index, [11] in_pause, [12] frame_end,
	// [15:13] zero
	logic [gsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	gait_sequenced_servo_pwm dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Register copies kept by the predictor
	logic [11:0] pwm_top;
	logic [7:0]  frames_goal;
	logic [15:0] pause_len;

	// Counter state kept by the predictor
	logic [11:0] tick_cnt;
	logic [7:0]  frame_cnt;
	logic [2:0]  gait_pos;
	logic [15:0] pause_cnt;
	bit          pausing_now;

	// Pin reports still owed by the block, oldest first
	logic [15:0] pin_report_q[$];

	int          fails;
	int unsigned cycle_cnt;
	bit          tx_calm;
	bit          rx_calm;
	int unsigned rx_hold_req;

	// One row of the directed plan: a register write or a tick transfer
	typedef struct {
		bit                  is_write;
		gsp_pkg::reg_index_t idx;
		logic [15:0]         val;
		bit                  tick;
		bit                  typed;
		logic [15:0]         want;
	} plan_row_t;

	plan_row_t dir_plan[$];

	// Clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Pin report for the current state, then the state update of one tick
	function automatic logic [15:0] servo_outputs_for_tick(input bit advance);
		logic [47:0] widths;
		logic [7:0]  pins;
		logic [15:0] report;
		bit          wrap;
		int          lane;
		pins = 8'h00;
		wrap = 1'b0;
		// Pulse widths of channels 1 to 4, channel 1 in the lowest field
		case (gait_pos)
			3'd0: widths = {12'd40, 12'd80, 12'd40, 12'd80};
			3'd1: widths = {12'd50, 12'd80, 12'd30, 12'd80};
			3'd2: widths = {12'd50, 12'd57, 12'd30, 12'd103};
			3'd3: widths = {12'd30, 12'd57, 12'd50, 12'd103};
			3'd4: widths = {12'd30, 12'd80, 12'd50, 12'd80};
			default: widths = {12'd40, 12'd80, 12'd40, 12'd80};
		endcase
		if (!pausing_now) begin
			for (lane = 0; lane < 4; lane++) begin
				if (tick_cnt < widths[lane*12 +: 12]) begin
					pins[lane]     = 1'b1;
					pins[lane + 4] = 1'b1;
				end
			end
		end
		report = {3'b000, 1'b0, pausing_now, gait_pos, pins};
		if (advance) begin
			if (pausing_now) begin
				pause_cnt = pause_cnt + 16'd1;
				if (pause_cnt >= pause_len || pause_cnt == 16'd0) begin
					pausing_now = 1'b0;
					pause_cnt   = 16'd0;
					gait_pos    = (int'(gait_pos) + 1 >= GAIT_STEPS) ? 3'd0 : gait_pos + 3'd1;
				end
			end else if (tick_cnt < pwm_top) begin
				tick_cnt = tick_cnt + 12'd1;
			end else begin
				tick_cnt = 12'd0;
				wrap     = 1'b1;
				if (int'(frame_cnt) + 1 >= int'(frames_goal)) begin
					frame_cnt = 8'd0;
					pause_cnt = 16'd0;
					if (pause_len == 16'd0)
						gait_pos = (int'(gait_pos) + 1 >= GAIT_STEPS) ? 3'd0 : gait_pos + 3'd1;
					else
						pausing_now = 1'b1;
				end else begin
					frame_cnt = frame_cnt + 8'd1;
				end
			end
		end
		report[12] = wrap;
		return report;
	endfunction

	// Register write; the caller only does this while the block is idle
	task automatic write_reg(input gsp_pkg::reg_index_t idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			gsp_pkg::REG_PERIOD_TOP:      pwm_top     = val[11:0];
			gsp_pkg::REG_FRAMES_PER_STEP: frames_goal = val[7:0];
			gsp_pkg::REG_PAUSE_TICKS:     pause_len   = val;
			default: ;
		endcase
	endtask

	// One tick item: optional gap, then hold it until the transfer
	task automatic send_tick(input bit tv, input bit typed, input logic [15:0] want);
		int unsigned gap;
		logic [15:0] predicted;
		cfg_we <= 1'b0;
		gap = tx_calm ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(gsp_pkg::IN_TDATA_W-1){1'b0}}, tv};
		do
			@(posedge clk);
		while (!s_axis_tready);
		predicted = servo_outputs_for_tick(tv);
		pin_report_q.push_back(typed ? want : predicted);
	endtask

	// Stop offering items and wait for every pending report
	task automatic wait_reports_done();
		s_axis_tvalid <= 1'b0;
		while (pin_report_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic plan_write(input gsp_pkg::reg_index_t idx, input logic [15:0] val);
		plan_row_t row;
		row = '{is_write: 1'b1, idx: idx, val: val, tick: 1'b0, typed: 1'b0, want: 16'h0};
		dir_plan.push_back(row);
	endtask

	task automatic plan_tick(input bit tv, input bit typed, input logic [15:0] want);
		plan_row_t row;
		row = '{is_write: 1'b0, idx: gsp_pkg::REG_PERIOD_TOP, val: 16'h0, tick: tv,
			typed: typed, want: want};
		dir_plan.push_back(row);
	endtask

	// Stimulus
	initial begin
		bit          last_was_tick;
		int unsigned sent;
		int unsigned phase;
		int unsigned n_ticks;
		int unsigned k;
		int unsigned pick;
		logic [15:0] val;

		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= gsp_pkg::REG_PERIOD_TOP;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		fails       = 0;
		tx_calm     = 1'b1;
		rx_calm     = 1'b1;
		rx_hold_req = 0;

		pwm_top     = gsp_pkg::PERIOD_TOP_RST;
		frames_goal = gsp_pkg::FRAMES_PER_STEP_RST;
		pause_len   = gsp_pkg::PAUSE_TICKS_RST;
		tick_cnt    = 12'd0;
		frame_cnt   = 8'd0;
		gait_pos    = 3'd0;
		pause_cnt   = 16'd0;
		pausing_now = 1'b0;

		// Idle tick and first tick after reset: all pins high at step 0
		plan_tick(1'b0, 1'b1, 16'h00FF);
		plan_tick(1'b1, 1'b1, 16'h00FF);
		// Period top of 1, zero frame count, zero pause: each wrap steps the gait
		plan_write(gsp_pkg::REG_PERIOD_TOP, 16'd1);
		plan_write(gsp_pkg::REG_FRAMES_PER_STEP, 16'd0);
		plan_write(gsp_pkg::REG_PAUSE_TICKS, 16'd0);
		plan_tick(1'b1, 1'b1, 16'h10FF);
		plan_tick(1'b1, 1'b0, 16'h0);
		plan_tick(1'b1, 1'b0, 16'h0);
		// Two-tick pause with an idle tick inside it
		plan_write(gsp_pkg::REG_PAUSE_TICKS, 16'd2);
		plan_tick(1'b1, 1'b0, 16'h0);
		plan_tick(1'b1, 1'b0, 16'h0);
		plan_tick(1'b1, 1'b0, 16'h0);
		plan_tick(1'b0, 1'b0, 16'h0);
		plan_tick(1'b1, 1'b0, 16'h0);
		plan_tick(1'b1, 1'b0, 16'h0);
		// Longest period, then a top below the tick count forces a wrap
		plan_write(gsp_pkg::REG_PERIOD_TOP, 16'd4095);
		plan_tick(1'b1, 1'b0, 16'h0);
		plan_tick(1'b1, 1'b0, 16'h0);
		plan_tick(1'b1, 1'b0, 16'h0);
		plan_write(gsp_pkg::REG_PERIOD_TOP, 16'd2);
		plan_tick(1'b1, 1'b1, 16'h13FF);
		// Longest pause, cut short by a lower pause length
		plan_write(gsp_pkg::REG_FRAMES_PER_STEP, 16'd255);
		plan_write(gsp_pkg::REG_PAUSE_TICKS, 16'd65535);
		plan_tick(1'b1, 1'b0, 16'h0);
		plan_write(gsp_pkg::REG_PAUSE_TICKS, 16'd1);
		plan_tick(1'b1, 1'b0, 16'h0);
		plan_tick(1'b1, 1'b0, 16'h0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan
		last_was_tick = 1'b0;
		foreach (dir_plan[i]) begin
			if (dir_plan[i].is_write) begin
				if (last_was_tick)
					wait_reports_done();
				write_reg(dir_plan[i].idx, dir_plan[i].val);
				last_was_tick = 1'b0;
			end else begin
				send_tick(dir_plan[i].tick, dir_plan[i].typed, dir_plan[i].want);
				last_was_tick = 1'b1;
			end
		end

		// Random phases: idle, write registers, then a run of ticks
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_TICKS) begin
			wait_reports_done();

			pick = $urandom_range(0, 9);
			if (pick < 6)
				val = 16'($urandom_range(20, 130));
			else if (pick < 8)
				val = 16'($urandom_range(1, 12));
			else if (pick == 8)
				val = 16'($urandom_range(131, 4095));
			else
				val = 16'd4095;
			if (phase == 0 || $urandom_range(0, 2) != 0)
				write_reg(gsp_pkg::REG_PERIOD_TOP, val);

			pick = $urandom_range(0, 9);
			if (pick < 7)
				val = 16'($urandom_range(1, 3));
			else if (pick == 7)
				val = 16'd0;
			else if (pick == 8)
				val = 16'($urandom_range(4, 20));
			else
				val = 16'd255;
			if (phase == 0 || $urandom_range(0, 2) != 0)
				write_reg(gsp_pkg::REG_FRAMES_PER_STEP, val);

			pick = $urandom_range(0, 9);
			if (pick < 5)
				val = 16'($urandom_range(1, 30));
			else if (pick < 8)
				val = 16'd0;
			else if (pick == 8)
				val = 16'($urandom_range(31, 300));
			else
				val = 16'd65535;
			if (phase == 0 || $urandom_range(0, 2) != 0)
				write_reg(gsp_pkg::REG_PAUSE_TICKS, val);

			// Mostly idling phases, some back-to-back ones
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			n_ticks = $urandom_range(20, 160);

			// Long receiver hold-off while ticks keep coming
			if (phase == 2) begin
				tx_calm     = 1'b1;
				rx_hold_req = LONG_HOLD;
				n_ticks     = 150;
			end

			for (k = 0; k < n_ticks; k++)
				send_tick($urandom_range(0, 6) != 0, 1'b0, 16'h0);
			sent  = sent + n_ticks;
			phase = phase + 1;
		end

		wait_reports_done();
		repeat (SETTLE) @(posedge clk);
		if (fails == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Receiver: a random gap after each transfer, plus the long hold-off on request
	initial begin
		int unsigned rx_gap;
		int unsigned rx_hold;
		rx_gap  = 0;
		rx_hold = 0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				rx_hold     = rx_hold_req;
				rx_hold_req = 0;
			end
			if (m_axis_tvalid && m_axis_tready)
				rx_gap = rx_calm ? 0 : $urandom_range(0, 13);
			if (rx_hold != 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Result checker: each transfer against the oldest pending report
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pin_report_q.size() == 0) begin
				$error("result transfer with no report pending: tdata %h", m_axis_tdata);
				fails++;
			end else begin
				want = pin_report_q.pop_front();
				if (m_axis_tdata[7:0] !== want[7:0]) begin
					$error("pin_bits: expected %h, got %h", want[7:0], m_axis_tdata[7:0]);
					fails++;
				end
				if (m_axis_tdata[10:8] !== want[10:8]) begin
					$error("step_index: expected %0d, got %0d", want[10:8], m_axis_tdata[10:8]);
					fails++;
				end
				if (m_axis_tdata[11] !== want[11]) begin
					$error("in_pause: expected %b, got %b", want[11], m_axis_tdata[11]);
					fails++;
				end
				if (m_axis_tdata[12] !== want[12]) begin
					$error("frame_end: expected %b, got %b", want[12], m_axis_tdata[12]);
					fails++;
				end
			end
		end
	end

	// Watchdog
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

endmodule
